// File: src/staggered_halo_box_calc_core_assert.svh
// Assertion macros for the staggered halo box calculator.
// Expects signals named clk and rst in the scope of each use.
`ifndef STAGGERED_HALO_BOX_CALC_CORE_ASSERT_SVH
`define STAGGERED_HALO_BOX_CALC_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SHBC_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("shbc: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define SHBC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("shbc: next-cycle check failed");

`endif

// File: src/shbc_pkg.sv
// Shared types, codes and helpers for the staggered halo box calculator.
// No dependencies; used by the request channel interface and the core.
package shbc_pkg;

  localparam int ACT_BITS      = 4;
  localparam int LOC_BITS      = 3;
  localparam int DIR_BITS      = 3;
  localparam int CELL_BITS     = 14;
  localparam int GHOST_BITS    = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 14;
  // offset term c + s*g spans -16..16
  localparam int K_BITS        = 6;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_OWNED       = 4'd0,
    ACT_ALLOCATED   = 4'd1,
    ACT_DOF         = 4'd2,
    ACT_INNER       = 4'd3,
    ACT_GHOST       = 4'd4,
    ACT_CORNER2     = 4'd5,
    ACT_CORNER2_MIX = 4'd6,
    ACT_CORNER3     = 4'd7,
    ACT_CORNER3_MIX = 4'd8,
    ACT_BOUND_SLAB  = 4'd9,
    ACT_GHOST_SLAB  = 4'd10,
    ACT_FACE_SLAB   = 4'd11,
    ACT_EDGE_SLAB   = 4'd12,
    ACT_VERTEX_SLAB = 4'd13
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CELLS_I = 2'd0,
    REG_CELLS_J = 2'd1,
    REG_CELLS_K = 2'd2,
    REG_GHOST   = 2'd3
  } cfg_reg_t;

  typedef enum logic [LOC_BITS-1:0] {
    LOC_CELL   = 3'd0,
    LOC_NODE   = 3'd1,
    LOC_FACE_I = 3'd2,
    LOC_FACE_J = 3'd3,
    LOC_FACE_K = 3'd4,
    LOC_EDGE_I = 3'd5,
    LOC_EDGE_J = 3'd6,
    LOC_EDGE_K = 3'd7
  } location_t;

  // Base value that a bound is built from
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_OWN,
    BASE_ILO,
    BASE_IHI
  } base_sel_t;

  // One bound = base + c + s*g
  typedef struct packed {
    base_sel_t         base;
    logic signed [1:0] c;
    logic signed [1:0] s;
  } bound_ctl_t;

  typedef struct packed {
    bound_ctl_t lo;
    bound_ctl_t hi;
  } axis_ctl_t;

  // Per-axis dof offset, bit a belongs to axis a
  function automatic logic [2:0] loc_offset(input logic [LOC_BITS-1:0] loc);
    logic [2:0] r;
    unique case (location_t'(loc))
      LOC_CELL:   r = 3'b111;
      LOC_NODE:   r = 3'b000;
      LOC_FACE_I: r = 3'b110;
      LOC_FACE_J: r = 3'b101;
      LOC_FACE_K: r = 3'b011;
      LOC_EDGE_I: r = 3'b001;
      LOC_EDGE_J: r = 3'b010;
      LOC_EDGE_K: r = 3'b100;
      default:    r = 3'b000;
    endcase
    return r;
  endfunction

  // A direction code names an axis unless it is zero or the most negative code
  function automatic logic dir_valid(input logic signed [DIR_BITS-1:0] v);
    return (v != 3'sd0) && (v != 3'b100);
  endfunction

  function automatic logic [1:0] dir_axis(input logic signed [DIR_BITS-1:0] v);
    logic [2:0] mag;
    mag = v[2] ? 3'(-v) : 3'(v);
    return 2'(mag - 3'd1);
  endfunction

endpackage

// File: src/shbc_if.sv
// Request and response channel interfaces for the staggered halo box calculator.
// Depends on shbc_pkg for field widths.
interface shbc_req_if #(parameter int COORD_BITS = 16);
  import shbc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [ACT_BITS-1:0]          action;
  logic [LOC_BITS-1:0]          location;
  logic signed [COORD_BITS-1:0] in_lo_i;
  logic signed [COORD_BITS-1:0] in_lo_j;
  logic signed [COORD_BITS-1:0] in_lo_k;
  logic signed [COORD_BITS-1:0] in_hi_i;
  logic signed [COORD_BITS-1:0] in_hi_j;
  logic signed [COORD_BITS-1:0] in_hi_k;
  logic signed [DIR_BITS-1:0]   dir_first;
  logic signed [DIR_BITS-1:0]   dir_second;
  logic signed [DIR_BITS-1:0]   dir_third;

  modport source (
    output valid, action, location, in_lo_i, in_lo_j, in_lo_k,
    output in_hi_i, in_hi_j, in_hi_k, dir_first, dir_second, dir_third,
    input  ready
  );
  modport sink (
    input  valid, action, location, in_lo_i, in_lo_j, in_lo_k,
    input  in_hi_i, in_hi_j, in_hi_k, dir_first, dir_second, dir_third,
    output ready
  );
endinterface

interface shbc_rsp_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_lo_i;
  logic signed [COORD_BITS-1:0] out_lo_j;
  logic signed [COORD_BITS-1:0] out_lo_k;
  logic signed [COORD_BITS-1:0] out_hi_i;
  logic signed [COORD_BITS-1:0] out_hi_j;
  logic signed [COORD_BITS-1:0] out_hi_k;
  logic                         bad_request;

  modport source (
    output valid, out_lo_i, out_lo_j, out_lo_k, out_hi_i, out_hi_j, out_hi_k,
    output bad_request,
    input  ready
  );
  modport sink (
    input  valid, out_lo_i, out_lo_j, out_lo_k, out_hi_i, out_hi_j, out_hi_k,
    input  bad_request,
    output ready
  );
endinterface

// File: src/staggered_halo_box_calc_core.sv
// An accepted request word reaches its response word through the decode, operand
// select and final add stages, each stage a register.
// Throughput: one word per cycle; each stage advances when the one after it
// is empty or moving, so a stalled response holds without dropping words.
// Reset (rst, synchronous): clears all stage valid bits and sets the cell
// counts to 1 and the ghost width to 1.
`include "staggered_halo_box_calc_core_assert.svh"

module staggered_halo_box_calc_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_en,
  input  logic [shbc_pkg::CFG_IDX_BITS-1:0]    reg_index,
  input  logic [shbc_pkg::CFG_DATA_BITS-1:0]   write_data,
  shbc_req_if.sink                             req,
  shbc_rsp_if.source                           rsp
);
  import shbc_pkg::*;

  localparam int WIDE_BITS = COORD_BITS + CELL_BITS;

  // configuration
  logic [CELL_BITS-1:0]  cells_i;
  logic [CELL_BITS-1:0]  cells_j;
  logic [CELL_BITS-1:0]  cells_k;
  logic [GHOST_BITS-1:0] ghost_width;

  // stage 1: decoded controls
  logic                         v1;
  logic                         bad1;
  axis_ctl_t                    ctl1 [3];
  logic signed [COORD_BITS-1:0] ilo1 [3];
  logic signed [COORD_BITS-1:0] ihi1 [3];
  logic signed [COORD_BITS-1:0] own1 [3];

  // stage 2: selected bases and small offsets
  logic                         v2;
  logic                         bad2;
  logic signed [COORD_BITS-1:0] base2 [6];
  logic signed [K_BITS-1:0]     k2 [6];

  // stage 3: output register
  logic                         v3;
  logic                         bad3;
  logic signed [COORD_BITS-1:0] res3 [6];
  logic                         res3_zero;

  // handshake
  logic ld1, ld2, ld3;

  // decode signals
  logic [2:0]                 offs;
  logic signed [DIR_BITS-1:0] dir_v [3];
  logic [1:0]                 ax [3];
  logic [1:0]                 need;
  logic                       act_bad;
  logic                       dir_bad;
  logic                       clash;
  logic                       bad_d;
  axis_ctl_t                  ctl_d [3];
  logic [CELL_BITS-1:0]       cells_v [3];
  logic [WIDE_BITS-1:0]       own_w [3];

  // stage 2 signals
  logic signed [COORD_BITS-1:0] base_d [6];
  logic signed [K_BITS-1:0]     k_d [6];
  logic signed [K_BITS-1:0]     gpos;

  // stage 3 signals
  logic signed [COORD_BITS-1:0] res_d [6];

  // Build the control for one axis from the kind and the direction that hits it
  function automatic axis_ctl_t axis_decode(input logic [ACT_BITS-1:0] act,
                                            input logic first, input logic other,
                                            input logic neg, input logic d);
    axis_ctl_t         r;
    logic              hit;
    logic signed [1:0] dneg;
    logic signed [1:0] e;
    hit  = first | other;
    dneg = d ? -2'sd1 : 2'sd0;
    e    = d ? 2'sd0 : 2'sd1;
    // dof range of the input box
    r.lo = '{BASE_ILO, 2'sd0, 2'sd0};
    r.hi = '{BASE_IHI, dneg, 2'sd0};
    case (act) inside
      ACT_OWNED: begin
        r.lo = '{BASE_ZERO, 2'sd0, 2'sd0};
        r.hi = '{BASE_OWN, 2'sd0, 2'sd0};
      end
      ACT_ALLOCATED: begin
        r.lo = '{BASE_ZERO, 2'sd0, -2'sd1};
        r.hi = '{BASE_OWN, 2'sd0, 2'sd1};
      end
      ACT_DOF: begin
      end
      ACT_INNER, ACT_GHOST, ACT_CORNER2, ACT_CORNER2_MIX, ACT_CORNER3,
      ACT_CORNER3_MIX: begin
        if (first && (act == ACT_INNER || act == ACT_CORNER2_MIX ||
                      act == ACT_CORNER3_MIX)) begin
          // inner strip skips the shared node layer
          if (neg) begin
            r.lo = '{BASE_ILO, e, 2'sd0};
            r.hi = '{BASE_ILO, e, 2'sd1};
          end else begin
            r.lo = '{BASE_IHI, -2'sd1, -2'sd1};
            r.hi = '{BASE_IHI, -2'sd1, 2'sd0};
          end
        end else if (hit) begin
          // ghost strip
          if (neg) begin
            r.lo = '{BASE_ZERO, 2'sd0, -2'sd1};
            r.hi = '{BASE_ZERO, 2'sd0, 2'sd0};
          end else begin
            r.lo = '{BASE_IHI, dneg, 2'sd0};
            r.hi = '{BASE_IHI, dneg, 2'sd1};
          end
        end
      end
      ACT_BOUND_SLAB: begin
        if (hit) begin
          if (neg) begin
            r.lo = '{BASE_ZERO, 2'sd0, 2'sd0};
            r.hi = '{BASE_ZERO, 2'sd1, 2'sd0};
          end else begin
            r.lo = '{BASE_OWN, -2'sd1, 2'sd0};
            r.hi = '{BASE_OWN, 2'sd0, 2'sd0};
          end
        end
      end
      ACT_GHOST_SLAB: begin
        r.hi = '{BASE_IHI, 2'sd0, 2'sd0};
        if (hit) begin
          if (neg) begin
            r.lo = '{BASE_ILO, 2'sd0, -2'sd1};
            r.hi = '{BASE_ILO, 2'sd0, 2'sd0};
          end else begin
            r.lo = '{BASE_IHI, 2'sd0, 2'sd0};
            r.hi = '{BASE_IHI, 2'sd0, 2'sd1};
          end
        end
      end
      ACT_FACE_SLAB, ACT_EDGE_SLAB, ACT_VERTEX_SLAB: begin
        // coupling range outside the owned region
        if (hit) begin
          if (neg) begin
            r.lo = '{BASE_ZERO, 2'sd0, -2'sd1};
            r.hi = '{BASE_ZERO, 2'sd0, 2'sd0};
          end else begin
            r.lo = '{BASE_OWN, 2'sd0, 2'sd0};
            r.hi = '{BASE_OWN, 2'sd0, 2'sd1};
          end
        end
      end
      default: begin
        r.lo = '{BASE_ZERO, 2'sd0, 2'sd0};
        r.hi = '{BASE_ZERO, 2'sd0, 2'sd0};
      end
    endcase
    return r;
  endfunction

  // Offset term c + s*g
  function automatic logic signed [K_BITS-1:0] bound_k(input bound_ctl_t b,
                                                       input logic signed [K_BITS-1:0] g);
    logic signed [K_BITS-1:0] gterm;
    logic signed [K_BITS-1:0] cext;
    if (b.s == 2'sd1) begin
      gterm = g;
    end else if (b.s == -2'sd1) begin
      gterm = -g;
    end else begin
      gterm = '0;
    end
    cext = {{(K_BITS-2){b.c[1]}}, b.c};
    return cext + gterm;
  endfunction

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_i     <= CELL_BITS'(1);
      cells_j     <= CELL_BITS'(1);
      cells_k     <= CELL_BITS'(1);
      ghost_width <= GHOST_BITS'(1);
    end else if (write_en) begin
      unique case (cfg_reg_t'(reg_index))
        REG_CELLS_I: cells_i     <= write_data[CELL_BITS-1:0];
        REG_CELLS_J: cells_j     <= write_data[CELL_BITS-1:0];
        REG_CELLS_K: cells_k     <= write_data[CELL_BITS-1:0];
        REG_GHOST:   ghost_width <= write_data[GHOST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: each stage loads when empty or when the next one moves
  assign ld3       = !v3 || rsp.ready;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign req.ready = ld1;

  // Decode the request word
  always_comb begin
    offs     = loc_offset(req.location);
    dir_v[0] = req.dir_first;
    dir_v[1] = req.dir_second;
    dir_v[2] = req.dir_third;
    for (int n = 0; n < 3; n++) begin
      ax[n] = dir_axis(dir_v[n]);
    end
    act_bad = 1'b0;
    case (req.action) inside
      ACT_INNER, ACT_GHOST, ACT_BOUND_SLAB, ACT_GHOST_SLAB, ACT_FACE_SLAB: need = 2'd1;
      ACT_CORNER2, ACT_CORNER2_MIX, ACT_EDGE_SLAB:                       need = 2'd2;
      ACT_CORNER3, ACT_CORNER3_MIX, ACT_VERTEX_SLAB:                     need = 2'd3;
      ACT_OWNED, ACT_ALLOCATED, ACT_DOF:                                 need = 2'd0;
      default: begin
        need    = 2'd0;
        act_bad = 1'b1;
      end
    endcase
    dir_bad = ((need >= 2'd1) && !dir_valid(dir_v[0])) ||
              ((need >= 2'd2) && !dir_valid(dir_v[1])) ||
              ((need == 2'd3) && !dir_valid(dir_v[2]));
    clash   = ((need >= 2'd2) && (ax[0] == ax[1])) ||
              ((need == 2'd3) && ((ax[0] == ax[2]) || (ax[1] == ax[2])));
    bad_d   = act_bad || dir_bad || clash;

    cells_v[0] = cells_i;
    cells_v[1] = cells_j;
    cells_v[2] = cells_k;
    for (int a = 0; a < 3; a++) begin
      logic first, second, third, neg;
      first  = (need >= 2'd1) && (ax[0] == 2'(a));
      second = (need >= 2'd2) && (ax[1] == 2'(a));
      third  = (need == 2'd3) && (ax[2] == 2'(a));
      neg    = first ? dir_v[0][2] : (second ? dir_v[1][2] : dir_v[2][2]);
      if (bad_d) begin
        ctl_d[a].lo = '{BASE_ZERO, 2'sd0, 2'sd0};
        ctl_d[a].hi = '{BASE_ZERO, 2'sd0, 2'sd0};
      end else begin
        ctl_d[a] = axis_decode(req.action, first, second | third, neg, offs[a]);
      end
      // node count minus the dof offset, wrapped to the coordinate width
      own_w[a] = WIDE_BITS'(cells_v[a]) + WIDE_BITS'(1) - WIDE_BITS'(offs[a]);
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && req.valid) begin
      bad1    <= bad_d;
      ctl1    <= ctl_d;
      ilo1[0] <= req.in_lo_i;
      ilo1[1] <= req.in_lo_j;
      ilo1[2] <= req.in_lo_k;
      ihi1[0] <= req.in_hi_i;
      ihi1[1] <= req.in_hi_j;
      ihi1[2] <= req.in_hi_k;
      for (int a = 0; a < 3; a++) begin
        own1[a] <= own_w[a][COORD_BITS-1:0];
      end
    end
  end

  // Select the base of each bound and form its small offset
  always_comb begin
    gpos = K_BITS'(ghost_width);
    for (int a = 0; a < 3; a++) begin
      for (int h = 0; h < 2; h++) begin
        bound_ctl_t b;
        b = (h == 0) ? ctl1[a].lo : ctl1[a].hi;
        unique case (b.base)
          BASE_ZERO: base_d[3*h+a] = '0;
          BASE_OWN:  base_d[3*h+a] = own1[a];
          BASE_ILO:  base_d[3*h+a] = ilo1[a];
          BASE_IHI:  base_d[3*h+a] = ihi1[a];
          default:   base_d[3*h+a] = '0;
        endcase
        k_d[3*h+a] = bound_k(b, gpos);
      end
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1) begin
      bad2  <= bad1;
      base2 <= base_d;
      k2    <= k_d;
    end
  end

  // Final add, wrapped to the coordinate width
  always_comb begin
    for (int n = 0; n < 6; n++) begin
      res_d[n] = base2[n] + {{(COORD_BITS-K_BITS){k2[n][K_BITS-1]}}, k2[n]};
    end
  end

  // Stage 3 output register: hold while the response is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && v2) begin
      bad3 <= bad2;
      res3 <= res_d;
    end
  end

  assign rsp.valid       = v3;
  assign rsp.out_lo_i    = res3[0];
  assign rsp.out_lo_j    = res3[1];
  assign rsp.out_lo_k    = res3[2];
  assign rsp.out_hi_i    = res3[3];
  assign rsp.out_hi_j    = res3[4];
  assign rsp.out_hi_k    = res3[5];
  assign rsp.bad_request = bad3;

  // Flag an all-zero output box
  assign res3_zero = (res3[0] == '0) && (res3[1] == '0) && (res3[2] == '0) &&
                     (res3[3] == '0) && (res3[4] == '0) && (res3[5] == '0);

  // A rejected request comes out as an all-zero box
  `SHBC_ASSERT_IMPLY(a_bad_zero_box, v3 && bad3, res3_zero)
  // Back-pressure reaches the request side only when every stage is full
  `SHBC_ASSERT_IMPLY(a_stall_full, !req.ready, v1 && v2 && v3)
  // A decoded word that moves on lands in stage 2
  `SHBC_ASSERT_NEXT(a_s1_to_s2, v1 && ld2, v2)
  // A word in stage 2 that moves on lands in the output register
  `SHBC_ASSERT_NEXT(a_s2_to_s3, v2 && ld3, v3)

endmodule
